### design/nst_pkg.sv
// ----------------------------------------------------------------------------
// nst_pkg
// Shared types and constants for the neighbor sequence table.
// ----------------------------------------------------------------------------
`default_nettype none

package nst_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW  = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW  = $clog2(TableEntries + 1);
  localparam int unsigned AddrW = IdxW + 1;
  localparam int unsigned PeerW = 7;
  localparam int unsigned SeqW  = 8;
  localparam int unsigned EntryW = PeerW + SeqW;

  typedef enum logic [0:0] {
    OpTx = 1'b0,
    OpRx = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  typedef struct packed {
    op_e              operation;
    logic [PeerW-1:0] peer_address;
    logic [SeqW-1:0]  frame_seq;
  } req_t;

  typedef struct packed {
    logic [SeqW-1:0] tx_seq;
    logic            accept;
    logic            table_full;
  } rsp_t;

  typedef struct packed {
    logic [PeerW-1:0] peer;
    logic [SeqW-1:0]  seq;
  } entry_t;

endpackage

`default_nettype wire

### design/nst_ram.sv
// ----------------------------------------------------------------------------
// nst_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned AddrW = 4
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### design/neighbor_sequence_table.sv
// ----------------------------------------------------------------------------
// neighbor_sequence_table
// Per-neighbor transmit sequence numbering and receive duplicate filtering.
// ----------------------------------------------------------------------------
// usage:
//   in channel : in_valid_i / in_stall_o, request in_req_i (operation, peer
//                address, frame sequence). out channel: out_valid_o /
//                out_stall_i, result out_rsp_o. one result per request.
//   both tables share one RAM, transmit table in the lower half and receive
//   table in the upper half; per-table fill counters mark the used slots.
//   a request scans the used slots of its table one RAM read per cycle,
//   stopping at the matching peer, at most 16 slots; address zero or an
//   empty table skips the scan and goes straight to the result.
//   one request is worked on at a time; the next one is accepted in the
//   cycle after the previous result reaches the output register. when the
//   receiver stalls, the result holds in the output register and a finished
//   request waits until that register frees up.
//   reset empties both tables at once by clearing the fill counters.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbor_sequence_table (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire nst_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output nst_pkg::rsp_t      out_rsp_o
);

  import nst_pkg::*;

  localparam logic [CntW-1:0] CntFull = CntW'(TableEntries);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  state_e          state_q, state_d;
  req_t            req_q, req_d;
  rsp_t            res_q, res_d;
  rsp_t            out_rsp_q, out_rsp_d;
  logic            out_valid_q, out_valid_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q [2];
  logic [CntW-1:0] cnt_d [2];

  logic             wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  entry_t           wr_data, rd_data;

  req_t            cur;
  logic [CntW-1:0] cur_cnt;
  logic [CntW-1:0] idx_nxt;
  logic            hit, miss;

  nst_ram #(
    .Width (EntryW),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q[0]    <= cnt_d[0];
      cnt_q[1]    <= cnt_d[1];
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    res_q     <= res_d;
    out_rsp_q <= out_rsp_d;
    idx_q     <= idx_d;
  end

  always_comb begin
    cur     = (state_q == StIdle) ? in_req_i : req_q;
    cur_cnt = cnt_q[cur.operation];
    idx_nxt = CntW'(idx_q) + CntOne;

    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    idx_d       = idx_q;
    cnt_d[0]    = cnt_q[0];
    cnt_d[1]    = cnt_q[1];
    out_rsp_d   = out_rsp_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = (state_q != StIdle);
    rd_en       = 1'b0;
    rd_addr     = {cur.operation, idx_q};
    wr_en       = 1'b0;
    wr_addr     = {cur.operation, idx_q};
    wr_data     = '{peer: cur.peer_address, seq: cur.frame_seq};
    hit         = 1'b0;
    miss        = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          req_d = in_req_i;
          if (in_req_i.peer_address == '0) begin
            res_d   = '0;
            state_d = StDone;
          end else if (cur_cnt == '0) begin
            miss    = 1'b1;
            state_d = StDone;
          end else begin
            rd_en   = 1'b1;
            rd_addr = {in_req_i.operation, IdxW'(0)};
            idx_d   = '0;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (rd_data.peer == req_q.peer_address) begin
          hit     = 1'b1;
          state_d = StDone;
        end else if (idx_nxt == cur_cnt) begin
          miss    = 1'b1;
          state_d = StDone;
        end else begin
          rd_en   = 1'b1;
          rd_addr = {req_q.operation, idx_nxt[IdxW-1:0]};
          idx_d   = idx_nxt[IdxW-1:0];
        end
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_rsp_d   = res_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // known peer: read-modify-write of its slot, unless a receive repeats the stored sequence
    if (hit) begin
      res_d = '0;
      if (req_q.operation == OpTx) begin
        res_d.tx_seq = rd_data.seq;
        wr_en        = 1'b1;
        wr_data.seq  = rd_data.seq + SeqW'(1);
      end else if (rd_data.seq != req_q.frame_seq) begin
        res_d.accept = 1'b1;
        wr_en        = 1'b1;
      end
    end

    // unknown peer: insert at the first free slot, unless the table is full
    if (miss) begin
      res_d        = '0;
      res_d.accept = (cur.operation == OpRx);
      if (cur_cnt == CntFull) begin
        res_d.table_full = 1'b1;
      end else begin
        wr_en                = 1'b1;
        wr_addr              = {cur.operation, cur_cnt[IdxW-1:0]};
        cnt_d[cur.operation] = cur_cnt + CntOne;
        if (cur.operation == OpTx) begin
          wr_data.seq = SeqW'(1);
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

### tb/neighbor_sequence_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// neighbor_sequence_table_tb
// Self-checking bench for the neighbor sequence table. A queue of requests
// (directed corner cases, table priming, a long transmit burst to one peer
// and a mixed random load) feeds a falling-edge driver; a rising-edge
// monitor keeps its own copy of both peer tables, predicts each result and
// compares it field by field as input idles and output stalls at random.
// ----------------------------------------------------------------------------
module neighbor_sequence_table_tb;
  import nst_pkg::*;

  localparam int unsigned PoolSize     = 24;
  localparam int unsigned WrapBurst    = 260;
  localparam int unsigned MixItems     = 1270;
  localparam int unsigned IdlePct      = 28;
  localparam int unsigned QuietLimit   = 1000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned CalmFirst    = 700;
  localparam int unsigned CalmLast     = 1000;

  typedef struct {
    req_t req;
    bit   drain;
  } queued_req_t;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  req_t in_req    = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_rsp;

  queued_req_t req_backlog[$];
  rsp_t        rsps_in_flight[$];

  logic [PeerW-1:0] tx_peers [TableEntries];
  logic [SeqW-1:0]  tx_next  [TableEntries];
  logic [PeerW-1:0] rx_peers [TableEntries];
  logic [SeqW-1:0]  rx_last  [TableEntries];
  int               tx_fill = 0;
  int               rx_fill = 0;

  int unsigned req_count    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches   = 0;
  logic        req_taken    = 1'b0;
  wire         calm = (req_count >= CalmFirst) && (req_count < CalmLast);

  neighbor_sequence_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  always #10 clk_i = ~clk_i;

  // applies one request to the local tables and returns its result
  function automatic rsp_t update_seq_tables(req_t r);
    rsp_t rsp;
    int   slot;
    rsp  = '0;
    slot = -1;
    if (r.peer_address != '0) begin
      if (r.operation == OpTx) begin
        for (int i = 0; i < tx_fill; i++) begin
          if (tx_peers[i] == r.peer_address) slot = i;
        end
        if (slot >= 0) begin
          rsp.tx_seq    = tx_next[slot];
          tx_next[slot] = tx_next[slot] + SeqW'(1);
        end else if (tx_fill < TableEntries) begin
          tx_peers[tx_fill] = r.peer_address;
          tx_next[tx_fill]  = SeqW'(1);
          tx_fill++;
        end else begin
          rsp.table_full = 1'b1;
        end
      end else begin
        for (int i = 0; i < rx_fill; i++) begin
          if (rx_peers[i] == r.peer_address) slot = i;
        end
        if (slot >= 0) begin
          if (rx_last[slot] != r.frame_seq) begin
            rsp.accept    = 1'b1;
            rx_last[slot] = r.frame_seq;
          end
        end else if (rx_fill < TableEntries) begin
          rx_peers[rx_fill] = r.peer_address;
          rx_last[rx_fill]  = r.frame_seq;
          rx_fill++;
          rsp.accept = 1'b1;
        end else begin
          rsp.table_full = 1'b1;
          rsp.accept     = 1'b1;
        end
      end
    end
    return rsp;
  endfunction

  task automatic add_request(input op_e op, input logic [PeerW-1:0] addr,
                             input logic [SeqW-1:0] seq, input bit drain);
    queued_req_t q;
    q.req.operation    = op;
    q.req.peer_address = addr;
    q.req.frame_seq    = seq;
    q.drain            = drain;
    req_backlog.push_back(q);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall <= !calm && ($urandom_range(99) < IdlePct);
      if (!in_valid || req_taken) begin
        if (req_backlog.size() != 0 &&
            !(req_backlog[0].drain && rsps_in_flight.size() != 0) &&
            (calm || $urandom_range(99) >= IdlePct)) begin
          in_req   <= req_backlog[0].req;
          in_valid <= 1'b1;
          req_backlog.delete(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t want;
    req_taken <= in_valid && !in_stall;
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (in_valid && !in_stall) begin
        rsps_in_flight.push_back(update_seq_tables(in_req));
        req_count++;
      end
      if (out_valid && !out_stall) begin
        if (rsps_in_flight.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_rsp);
        end else begin
          want = rsps_in_flight.pop_front();
          if (out_rsp.tx_seq !== want.tx_seq) begin
            mismatches++;
            $display("%0t: tx_seq expected %0d actual %0d",
                     $time, want.tx_seq, out_rsp.tx_seq);
          end
          if (out_rsp.accept !== want.accept) begin
            mismatches++;
            $display("%0t: accept expected %0b actual %0b",
                     $time, want.accept, out_rsp.accept);
          end
          if (out_rsp.table_full !== want.table_full) begin
            mismatches++;
            $display("%0t: table_full expected %0b actual %0b",
                     $time, want.table_full, out_rsp.table_full);
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    bit [SeqW-1:0]    last_sent [1 << PeerW];
    bit               taken [1 << PeerW];
    logic [PeerW-1:0] pool [PoolSize];
    logic [PeerW-1:0] addr;
    logic [SeqW-1:0]  seq;
    op_e              op;
    int unsigned      roll;

    // address zero, new peers, duplicates, sequence extremes
    add_request(OpTx, 7'd0,   8'hFF, 1'b0);
    add_request(OpRx, 7'd0,   8'hAA, 1'b0);
    add_request(OpTx, 7'd127, 8'h55, 1'b0);
    add_request(OpTx, 7'd127, 8'hFF, 1'b0);
    add_request(OpTx, 7'd127, 8'h00, 1'b0);
    add_request(OpRx, 7'd127, 8'hFF, 1'b0);
    add_request(OpRx, 7'd127, 8'hFF, 1'b0);
    add_request(OpRx, 7'd127, 8'h00, 1'b0);
    add_request(OpRx, 7'd127, 8'h00, 1'b0);
    add_request(OpTx, 7'd1,   8'h00, 1'b0);
    add_request(OpRx, 7'd1,   8'h00, 1'b0);
    add_request(OpRx, 7'd1,   8'h00, 1'b0);

    // distinct peers, more than a table holds, so both tables overflow
    for (int i = 0; i < PoolSize; i++) begin
      do addr = PeerW'($urandom_range(127, 1)); while (taken[addr]);
      taken[addr] = 1'b1;
      pool[i]     = addr;
      seq         = SeqW'($urandom_range(255));
      last_sent[addr] = seq;
      if ($urandom_range(1)) begin
        add_request(OpTx, addr, SeqW'($urandom_range(255)), i == 0);
        add_request(OpRx, addr, seq, 1'b0);
      end else begin
        add_request(OpRx, addr, seq, i == 0);
        add_request(OpTx, addr, SeqW'($urandom_range(255)), 1'b0);
      end
    end

    for (int i = 0; i < MixItems; i++) begin
      roll = $urandom_range(99);
      if (roll < 3) addr = '0;
      else if (roll < 80) addr = pool[$urandom_range(PoolSize - 1)];
      else addr = PeerW'($urandom_range(127, 1));
      op  = $urandom_range(1) ? OpRx : OpTx;
      seq = SeqW'($urandom_range(255));
      if (op == OpRx && $urandom_range(99) < 45) seq = last_sent[addr];
      if (op == OpRx) last_sent[addr] = seq;
      add_request(op, addr, seq, i == 600);
      // long burst to one peer so its counter wraps
      if (i == 300) begin
        for (int j = 0; j < WrapBurst; j++) begin
          add_request(OpTx, 7'd127, SeqW'($urandom_range(255)), j == 0);
        end
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (req_backlog.size() != 0 || in_valid || rsps_in_flight.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);

    if (rsps_in_flight.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/nst_pkg.sv
design/nst_ram.sv
design/neighbor_sequence_table.sv
tb/neighbor_sequence_table_tb.sv
